// File: sv/cal_pkg.sv
// shared types, constants and tables for the led calendar scan block
`default_nettype none
package cal_pkg;

  localparam int unsigned MONTHS     = 12;
  localparam int unsigned MONTH_W    = 4;
  localparam int unsigned DAY_W      = 5;
  localparam int unsigned DAYS_W     = 31;
  localparam int unsigned COL_W      = 12;
  localparam int unsigned CFG_W      = 8;
  localparam logic [7:0]  BRIGHT_MAX = 8'd200;
  localparam logic [7:0]  CMP_NONE   = 8'd255;
  localparam logic [MONTH_W-1:0] LAST_MONTH = 4'(MONTHS - 1);
  localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd30;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_TOGGLE = 2'd3
  } op_t;

  typedef enum logic {
    REG_STREAK_MODE = 1'b0,
    REG_BRIGHTNESS  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_EDIT,
    ST_WALK_RD,
    ST_WALK_DAY
  } state_t;

  typedef struct packed {
    logic               clr;
    logic               step;
    logic               lit;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } streak_step_t;

  // index of the last day of each month
  function automatic logic [DAY_W-1:0] month_last(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd27;
      4'd3:    r = 5'd29;
      4'd5:    r = 5'd29;
      4'd8:    r = 5'd29;
      4'd10:   r = 5'd29;
      default: r = 5'd30;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/cal_ram.sv
// generic single write port ram with registered read
`default_nettype none
module cal_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/cal_streak.sv
// streak tracker: first and last day of the latest lit run, rendered per column
`default_nettype none
module cal_streak (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cal_pkg::streak_step_t         ctl,
  input  wire logic [cal_pkg::MONTH_W-1:0]   col,
  output logic      [cal_pkg::DAYS_W-1:0]    render_bits
);
  import cal_pkg::*;

  logic               in_run;
  logic               have_run;
  logic [MONTH_W-1:0] s_m;
  logic [DAY_W-1:0]   s_d;
  logic [MONTH_W-1:0] e_m;
  logic [DAY_W-1:0]   e_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run   <= 1'b0;
      have_run <= 1'b0;
    end else if (ctl.clr) begin
      in_run   <= 1'b0;
      have_run <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.lit) begin
        if (!in_run) begin
          s_m      <= ctl.month;
          s_d      <= ctl.day;
          have_run <= 1'b1;
        end
        in_run <= 1'b1;
        e_m    <= ctl.month;
        e_d    <= ctl.day;
      end else begin
        in_run <= 1'b0;
      end
    end
  end

  always_comb begin
    render_bits = '0;
    if (have_run && s_m == col) begin
      render_bits = render_bits | (DAYS_W'(1) << s_d);
    end
    if (have_run && e_m == col) begin
      render_bits = render_bits | (DAYS_W'(1) << e_d);
    end
  end

endmodule
`default_nettype wire

// File: sv/calendar_led_matrix_scan_with_streak_top.sv
// top level of the led calendar: scan timer, day store, edit sequencer
// usage:
//   start/busy command channel carries op, month, day; a transaction is taken
//   when start is high and busy is low.
//   each transaction gives exactly one result, shown for one cycle with done
//   high; the receiver cannot stall, so it must take the result in that cycle.
//   timer tick: the day store row of the active column is read as the command
//   is taken, the tick state then forms the registered result; a new command
//   can be taken in the done cycle.
//   out-of-range edit: result the next cycle, busy stays low.
//   valid edit: a read-modify-write state, then the streak walk over the year,
//   one step per calendar day plus one row read per month through the single
//   ram read port, busy throughout, result in the cycle after.
//   cfg_we/cfg_index/cfg_data write streak_mode (index 0) and brightness_setting
//   (index 1); the user must write them only while idle, the block does not enforce it.
//   reset (rst, synchronous): day store reads as zero through per-row valid
//   bits, streak render empty, timer and column zero, leds blanked,
//   watchdog line high, streak_mode 0, brightness 128.
`default_nettype none
module calendar_led_matrix_scan_with_streak_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  op,
  input  wire logic [cal_pkg::MONTH_W-1:0] month,
  input  wire logic [cal_pkg::DAY_W-1:0]   day,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [cal_pkg::CFG_W-1:0]   cfg_data,
  output logic                             done,
  output logic                             frame_valid,
  output logic [cal_pkg::COL_W-1:0]        column_onehot,
  output logic [cal_pkg::DAYS_W-1:0]       day_bits,
  output logic                             leds_on,
  output logic                             watchdog_level,
  output logic                             day_state
);
  import cal_pkg::*;

  state_t             state, state_next;
  op_t                op_q, op_q_next;
  logic [MONTH_W-1:0] month_q, month_q_next;
  logic [DAY_W-1:0]   day_q, day_q_next;
  logic [MONTH_W-1:0] walk_m, walk_m_next;
  logic [DAY_W-1:0]   walk_d, walk_d_next;
  logic               dstate, dstate_next;

  logic [7:0]         timer_count, timer_count_next;
  logic [MONTH_W-1:0] active_column, active_column_next;
  logic               leds_flag, leds_flag_next;
  logic               wd_line, wd_line_next;
  logic               streak_mode;
  logic [7:0]         brightness;

  logic               done_next, fv_next, leds_on_next, wd_out_next, day_state_next;
  logic [COL_W-1:0]   col_next;
  logic [DAYS_W-1:0]  bits_next;

  logic [MONTHS-1:0]  row_valid;
  logic               rvalid;
  logic               ram_we;
  logic [MONTH_W-1:0] ram_waddr, ram_raddr;
  logic [DAYS_W-1:0]  ram_wdata, ram_rdata, word, new_word;
  logic [DAYS_W-1:0]  render_bits;
  streak_step_t       sctl;

  logic               accept, edit_ok;
  logic [7:0]         bclamp, cmp, tnext;
  logic [MONTH_W-1:0] col;

  cal_ram #(.WIDTH(DAYS_W), .DEPTH(MONTHS)) u_day_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cal_streak u_streak (
    .clk         (clk),
    .rst         (rst),
    .ctl         (sctl),
    .col         (col),
    .render_bits (render_bits)
  );

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign edit_ok = (month <= LAST_MONTH) && (day <= LAST_DAY);
  assign word    = rvalid ? ram_rdata : '0;
  assign bclamp  = (brightness > BRIGHT_MAX) ? BRIGHT_MAX : brightness;
  assign cmp     = CMP_NONE - bclamp;
  assign tnext   = timer_count + 8'd1;
  assign col     = (active_column <= LAST_MONTH) ? active_column : '0;

  always_comb begin
    case (op_q)
      OP_SET:    new_word = word | (DAYS_W'(1) << day_q);
      OP_CLEAR:  new_word = word & ~(DAYS_W'(1) << day_q);
      OP_TOGGLE: new_word = word ^ (DAYS_W'(1) << day_q);
      default:   new_word = word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (ram_we) begin
      row_valid[ram_waddr] <= 1'b1;
    end
    rvalid <= row_valid[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streak_mode <= 1'b0;
      brightness  <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STREAK_MODE: streak_mode <= cfg_data[0];
        REG_BRIGHTNESS:  brightness  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      timer_count   <= '0;
      active_column <= '0;
      leds_flag     <= 1'b0;
      wd_line       <= 1'b1;
      done          <= 1'b0;
    end else begin
      state         <= state_next;
      timer_count   <= timer_count_next;
      active_column <= active_column_next;
      leds_flag     <= leds_flag_next;
      wd_line       <= wd_line_next;
      done          <= done_next;
    end
    op_q           <= op_q_next;
    month_q        <= month_q_next;
    day_q          <= day_q_next;
    walk_m         <= walk_m_next;
    walk_d         <= walk_d_next;
    dstate         <= dstate_next;
    frame_valid    <= fv_next;
    column_onehot  <= col_next;
    day_bits       <= bits_next;
    leds_on        <= leds_on_next;
    watchdog_level <= wd_out_next;
    day_state      <= day_state_next;
  end

  always_comb begin
    state_next         = state;
    op_q_next          = op_q;
    month_q_next       = month_q;
    day_q_next         = day_q;
    walk_m_next        = walk_m;
    walk_d_next        = walk_d;
    dstate_next        = dstate;
    timer_count_next   = timer_count;
    active_column_next = active_column;
    leds_flag_next     = leds_flag;
    wd_line_next       = wd_line;
    done_next          = 1'b0;
    fv_next            = frame_valid;
    col_next           = column_onehot;
    bits_next          = day_bits;
    leds_on_next       = leds_on;
    wd_out_next        = watchdog_level;
    day_state_next     = day_state;
    ram_we             = 1'b0;
    ram_waddr          = month_q;
    ram_wdata          = new_word;
    ram_raddr          = walk_m;
    sctl               = '0;
    sctl.month         = walk_m;
    sctl.day           = walk_d;
    sctl.lit           = word[walk_d];

    case (state)
      ST_IDLE: begin
        ram_raddr = (op_t'(op) == OP_TICK) ? col : (edit_ok ? month : '0);
        if (accept) begin
          op_q_next    = op_t'(op);
          month_q_next = month;
          day_q_next   = day;
          if (op_t'(op) == OP_TICK) begin
            state_next = ST_TICK;
          end else if (edit_ok) begin
            state_next = ST_EDIT;
          end else begin
            // ignored edit
            done_next      = 1'b1;
            fv_next        = 1'b0;
            col_next       = '0;
            bits_next      = '0;
            leds_on_next   = leds_flag;
            wd_out_next    = wd_line;
            day_state_next = 1'b0;
          end
        end
      end
      ST_TICK: begin
        timer_count_next = tnext;
        fv_next          = 1'b0;
        col_next         = '0;
        bits_next        = '0;
        leds_on_next     = leds_flag;
        wd_out_next      = wd_line;
        if (tnext == 8'd0) begin
          leds_on_next       = 1'b0;
          wd_out_next        = !wd_line;
          fv_next            = 1'b1;
          col_next           = COL_W'(1) << col;
          bits_next          = streak_mode ? render_bits : word;
          active_column_next = (col == LAST_MONTH) ? '0 : col + 4'd1;
        end
        if (tnext == cmp && cmp != CMP_NONE) begin
          leds_on_next = 1'b1;
        end
        leds_flag_next = leds_on_next;
        wd_line_next   = wd_out_next;
        done_next      = 1'b1;
        day_state_next = 1'b0;
        state_next     = ST_IDLE;
      end
      ST_EDIT: begin
        ram_we      = 1'b1;
        dstate_next = new_word[day_q];
        sctl.clr    = 1'b1;
        walk_m_next = '0;
        walk_d_next = '0;
        state_next  = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        state_next = ST_WALK_DAY;
      end
      ST_WALK_DAY: begin
        sctl.step = 1'b1;
        if (walk_d == month_last(walk_m)) begin
          walk_d_next = '0;
          if (walk_m == LAST_MONTH) begin
            done_next      = 1'b1;
            fv_next        = 1'b0;
            col_next       = '0;
            bits_next      = '0;
            leds_on_next   = leds_flag;
            wd_out_next    = wd_line;
            day_state_next = dstate;
            state_next     = ST_IDLE;
          end else begin
            walk_m_next = walk_m + 4'd1;
            state_next  = ST_WALK_RD;
          end
        end else begin
          walk_d_next = walk_d + 5'd1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: dv/tb.sv
// self-checking testbench for the led calendar scan and streak block
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cal_pkg::*;

  typedef struct packed {
    logic               fv;
    logic [COL_W-1:0]   col;
    logic [DAYS_W-1:0]  bits;
    logic               leds;
    logic               wd;
    logic               ds;
  } scan_res_t;

  typedef struct packed {
    op_t                o;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic               chk;
    scan_res_t          ex;
  } dir_row_t;

  // state right after reset: no frame, leds blanked, watchdog high
  localparam scan_res_t QUIET0 = '{fv: 1'b0, col: '0, bits: '0, leds: 1'b0, wd: 1'b1, ds: 1'b0};
  localparam scan_res_t QUIET1 = '{fv: 1'b0, col: '0, bits: '0, leds: 1'b0, wd: 1'b1, ds: 1'b1};

  localparam int DIR_N = 23;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{OP_TICK,   4'd0,  5'd0,  1'b1, QUIET0},
    '{OP_SET,    4'd15, 5'd0,  1'b1, QUIET0},
    '{OP_SET,    4'd0,  5'd31, 1'b1, QUIET0},
    '{OP_TOGGLE, 4'd12, 5'd30, 1'b1, QUIET0},
    '{OP_CLEAR,  4'd15, 5'd31, 1'b1, QUIET0},
    '{OP_SET,    4'd0,  5'd0,  1'b1, QUIET1},
    '{OP_SET,    4'd11, 5'd30, 1'b1, QUIET1},
    '{OP_SET,    4'd1,  5'd29, 1'b1, QUIET1},
    '{OP_CLEAR,  4'd1,  5'd29, 1'b1, QUIET0},
    '{OP_TOGGLE, 4'd1,  5'd27, 1'b1, QUIET1},
    '{OP_SET,    4'd2,  5'd0,  1'b0, QUIET0},
    '{OP_TOGGLE, 4'd1,  5'd27, 1'b1, QUIET0},
    '{OP_SET,    4'd11, 5'd29, 1'b0, QUIET0},
    '{OP_SET,    4'd5,  5'd15, 1'b0, QUIET0},
    '{OP_SET,    4'd5,  5'd16, 1'b0, QUIET0},
    '{OP_SET,    4'd5,  5'd17, 1'b0, QUIET0},
    '{OP_CLEAR,  4'd11, 5'd30, 1'b1, QUIET0},
    '{OP_CLEAR,  4'd11, 5'd29, 1'b1, QUIET0},
    '{OP_CLEAR,  4'd5,  5'd16, 1'b1, QUIET0},
    '{OP_TICK,   4'd15, 5'd31, 1'b0, QUIET0},
    '{OP_CLEAR,  4'd0,  5'd0,  1'b1, QUIET0},
    '{OP_SET,    4'd11, 5'd30, 1'b0, QUIET0},
    '{OP_TICK,   4'd7,  5'd3,  1'b0, QUIET0}
  };

  localparam int MLEN [MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam logic [7:0] BRIGHT_PLAN [8] = '{8'd0, 8'd255, 8'd200, 8'd201, 8'd1, 8'd128,
                                             8'd54, 8'd77};

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          op = OP_TICK;
  logic [MONTH_W-1:0]  month = '0;
  logic [DAY_W-1:0]    day = '0;
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_STREAK_MODE;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                done;
  logic                frame_valid;
  logic [COL_W-1:0]    column_onehot;
  logic [DAYS_W-1:0]   day_bits;
  logic                leds_on;
  logic                watchdog_level;
  logic                day_state;

  calendar_led_matrix_scan_with_streak_top DUT (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .month          (month),
    .day            (day),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .frame_valid    (frame_valid),
    .column_onehot  (column_onehot),
    .day_bits       (day_bits),
    .leds_on        (leds_on),
    .watchdog_level (watchdog_level),
    .day_state      (day_state)
  );

  // predicted block state
  logic [DAYS_W-1:0] day_mem    [MONTHS];
  logic [DAYS_W-1:0] render_mem [MONTHS];
  logic [7:0]        tmr_p;
  logic [3:0]        col_p;
  logic              leds_p;
  logic              wd_p;
  logic              mode_p;
  logic [7:0]        bright_p;

  scan_res_t pending_q [$];
  int fails = 0;
  int n_items = 0;
  int n_edits = 0;
  int n_frames_seen = 0;
  int burst_left = 0;
  bit start_hi = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("timeout with %0d transactions outstanding", pending_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void calendar_reset();
    foreach (day_mem[i]) begin
      day_mem[i] = '0;
      render_mem[i] = '0;
    end
    tmr_p = '0;
    col_p = '0;
    leds_p = 1'b0;
    wd_p = 1'b1;
    mode_p = 1'b0;
    bright_p = 8'd128;
  endfunction

  // mark first and last day of the latest run of lit days
  function automatic void streak_rebuild();
    bit in_run;
    bit have_run;
    int sm, sd, em, ed;
    in_run = 1'b0;
    have_run = 1'b0;
    sm = 0;
    sd = 0;
    em = 0;
    ed = 0;
    foreach (render_mem[i]) render_mem[i] = '0;
    for (int m = 0; m < MONTHS; m++) begin
      for (int d = 0; d < MLEN[m]; d++) begin
        if (day_mem[m][d]) begin
          if (!in_run) begin
            sm = m;
            sd = d;
            have_run = 1'b1;
          end
          in_run = 1'b1;
          em = m;
          ed = d;
        end else begin
          in_run = 1'b0;
        end
      end
    end
    if (have_run) begin
      render_mem[sm][sd] = 1'b1;
      render_mem[em][ed] = 1'b1;
    end
  endfunction

  function automatic scan_res_t scan_predict(op_t o, logic [MONTH_W-1:0] m,
                                             logic [DAY_W-1:0] d);
    scan_res_t r;
    logic [7:0] b;
    logic [7:0] cmp;
    int c;
    r = '0;
    if (o == OP_TICK) begin
      b = (bright_p > BRIGHT_MAX) ? BRIGHT_MAX : bright_p;
      cmp = CMP_NONE - b;
      tmr_p = tmr_p + 8'd1;
      if (tmr_p == 8'd0) begin
        c = (col_p < MONTHS) ? int'(col_p) : 0;
        leds_p = 1'b0;
        wd_p = ~wd_p;
        r.fv = 1'b1;
        r.col = 12'd1 << c;
        r.bits = mode_p ? render_mem[c] : day_mem[c];
        col_p = 4'((c + 1) % MONTHS);
      end
      if (tmr_p == cmp && cmp != CMP_NONE) leds_p = 1'b1;
    end else if (m <= LAST_MONTH && d <= LAST_DAY) begin
      case (o)
        OP_SET:   day_mem[m][d] = 1'b1;
        OP_CLEAR: day_mem[m][d] = 1'b0;
        default:  day_mem[m][d] = ~day_mem[m][d];
      endcase
      streak_rebuild();
      r.ds = day_mem[m][d];
    end
    r.leds = leds_p;
    r.wd = wd_p;
    return r;
  endfunction

  // sender bursts with random gaps
  task automatic sender_pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      start <= 1'b0;
      start_hi = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 12);
    end
  endtask

  task automatic issue(op_t o, logic [MONTH_W-1:0] m, logic [DAY_W-1:0] d,
                       logic chk, scan_res_t ex);
    scan_res_t r;
    start <= 1'b1;
    start_hi = 1'b1;
    op <= o;
    month <= m;
    day <= d;
    do @(posedge clk); while (busy);
    r = scan_predict(o, m, d);
    pending_q.push_back(chk ? ex : r);
    n_items++;
    if (o != OP_TICK) n_edits++;
    sender_pace();
  endtask

  task automatic settle();
    if (start_hi) begin
      start <= 1'b0;
      start_hi = 1'b0;
    end
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] mode_v, logic [7:0] bright_v);
    cfg_we <= 1'b1;
    cfg_index <= REG_STREAK_MODE;
    cfg_data <= mode_v;
    @(posedge clk);
    mode_p = mode_v[0];
    cfg_index <= REG_BRIGHTNESS;
    cfg_data <= bright_v;
    @(posedge clk);
    bright_p = bright_v;
    cfg_we <= 1'b0;
  endtask

  function automatic void date_of(int idx, output logic [MONTH_W-1:0] m,
                                  output logic [DAY_W-1:0] d);
    int rem;
    rem = idx;
    m = '0;
    d = '0;
    for (int i = 0; i < MONTHS; i++) begin
      if (rem < MLEN[i]) begin
        m = 4'(i);
        d = 5'(rem);
        break;
      end
      rem -= MLEN[i];
    end
  endfunction

  // mostly ticks; edits cluster round a focus date so runs of lit days form
  task automatic random_item(int focus);
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0] d;
    int k;
    op_t o;
    if ($urandom_range(0, 99) < 70) begin
      issue(OP_TICK, 4'($urandom), 5'($urandom), 1'b0, '0);
    end else begin
      k = $urandom_range(0, 99);
      if (k < 60) begin
        date_of((focus + 361 + $urandom_range(0, 8)) % 365, m, d);
      end else if (k < 85) begin
        m = 4'($urandom_range(0, 11));
        d = 5'($urandom_range(0, 30));
      end else begin
        m = 4'($urandom);
        d = 5'($urandom);
      end
      k = $urandom_range(0, 9);
      o = (k < 6) ? OP_SET : (k < 8) ? OP_CLEAR : OP_TOGGLE;
      issue(o, m, d, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : result_check
    scan_res_t want;
    if (!rst && done) begin
      if (frame_valid) n_frames_seen++;
      if (pending_q.size() == 0) begin
        $error("result transaction with nothing expected");
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (frame_valid !== want.fv) begin
          $error("frame_valid expected %0h actual %0h", want.fv, frame_valid);
          fails++;
        end
        if (column_onehot !== want.col) begin
          $error("column_onehot expected %0h actual %0h", want.col, column_onehot);
          fails++;
        end
        if (day_bits !== want.bits) begin
          $error("day_bits expected %0h actual %0h", want.bits, day_bits);
          fails++;
        end
        if (leds_on !== want.leds) begin
          $error("leds_on expected %0h actual %0h", want.leds, leds_on);
          fails++;
        end
        if (watchdog_level !== want.wd) begin
          $error("watchdog_level expected %0h actual %0h", want.wd, watchdog_level);
          fails++;
        end
        if (day_state !== want.ds) begin
          $error("day_state expected %0h actual %0h", want.ds, day_state);
          fails++;
        end
      end
    end
  end

  initial begin
    int focus;
    calendar_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_TAB[i]) begin
      issue(DIR_TAB[i].o, DIR_TAB[i].m, DIR_TAB[i].d, DIR_TAB[i].chk, DIR_TAB[i].ex);
    end

    for (int p = 0; p < 8; p++) begin
      settle();
      write_regs({7'($urandom), 1'(p % 2)}, (p == 7) ? 8'($urandom) : BRIGHT_PLAN[p]);
      focus = (p == 0) ? 362 : $urandom_range(0, 364);
      repeat (85) random_item(focus);
    end

    settle();
    repeat (20) @(posedge clk);
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      fails++;
    end
    $display("ran %0d transactions, %0d of them day edits, over 8 register settings",
             n_items, n_edits);
    $display("checked %0d scan frames emitted on timer wrap", n_frames_seen);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
sv/cal_pkg.sv
sv/cal_ram.sv
sv/cal_streak.sv
sv/calendar_led_matrix_scan_with_streak_top.sv
dv/tb.sv
